// ===== rtl/core/rpsq_pkg.sv =====
package rpsq_pkg;

  // Marker and letter codes
  localparam logic [31:0] MARK_P = 32'h50;
  localparam logic [31:0] MARK_S = 32'h53;
  localparam logic [31:0] MARK_Q = 32'h51;
  localparam logic [31:0] MARK_G = 32'h67;

  localparam logic [7:0] CHR_A = 8'h41;
  localparam logic [7:0] CHR_C = 8'h43;
  localparam logic [7:0] CHR_G = 8'h47;
  localparam logic [7:0] CHR_T = 8'h54;

  // Error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_MARKER = 2'd1;
  localparam logic [1:0] ERR_INDEX  = 2'd2;
  localparam logic [1:0] ERR_GROUP  = 2'd3;

  // Input opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_TOKEN = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_ESCAPE  = 2'd0;
  localparam logic [1:0] CFG_OFFSET  = 2'd1;
  localparam logic [1:0] CFG_ENTRIES = 2'd2;

  // Result kinds
  localparam logic KIND_BASE    = 1'b0;
  localparam logic KIND_QUALITY = 1'b1;

  // Queue between parser and output side
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  // Result as it travels through the queue; char is raw table value for quality
  typedef struct packed {
    logic [7:0] chr;
    logic       kind;
    logic       half;
    logic       last_field;
    logic       last_pair;
    logic [1:0] err;
  } rpsq_entry_t;

  typedef struct packed {
    logic        valid;
    rpsq_entry_t entry;
  } rpsq_push_t;

  function automatic logic [7:0] base_letter(input logic [1:0] code);
    logic [7:0] r;
    case (code)
      2'd0:    r = CHR_A;
      2'd1:    r = CHR_C;
      2'd2:    r = CHR_G;
      default: r = CHR_T;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/read_pair_sequence_quality_decoder.sv =====
// Paired-read sequence and quality decoder.
//
// Input stream (s_axis_*): one request per decoded token or table load.
// tuser selects the request: 0 writes table_value into quality table entry
// table_index, 1 hands a token to the record parser. Configuration writes
// (escape code, phred offset, table entries in use) arrive on cfg_* and are
// always taken; write them only while the block is idle.
//
// Output stream (m_axis_*): base letters and quality characters in order,
// with tlast on the last char of each string and error results that drop
// the parser back to idle.
//
// A request that yields a result passes through the table read stage, the
// queue and the output register, in that order, before it shows on m_axis.
// Throughput is one request per cycle; the parser keeps accepting while
// results wait, until the queue and the read stage hold four results
// between them.
// Reset clears parser state and the queue; the table stays unwritten.
// A stalled receiver holds m_axis data steady and fills the queue.
module read_pair_sequence_quality_decoder
  import rpsq_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] token_value, [37:32] table_index, [45:38] table_value
  input  logic [47:0] s_axis_tdata,
  // [0] opcode
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_char
  output logic [7:0]  m_axis_tdata,
  // [0] out_kind, [1] pair_half, [2] last_of_pair, [4:3] error_code
  output logic [4:0]  m_axis_tuser,
  // last_of_field
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0]       escape_q;
  logic [7:0]        offset_q;
  logic [6:0]        entries_q;
  logic [QCNT_W-1:0] q_count;
  rpsq_push_t        push;
  rpsq_entry_t       res;

  // Configuration registers; writes to unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escape_q  <= 16'd255;
      offset_q  <= 8'd33;
      entries_q <= 7'd64;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ESCAPE:  escape_q  <= cfg_data_i;
        CFG_OFFSET:  offset_q  <= cfg_data_i[7:0];
        CFG_ENTRIES: entries_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Parser, table and read stage
  rpsq_front #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .opcode_i       (s_axis_tuser),
    .token_value_i  (s_axis_tdata[31:0]),
    .table_index_i  (s_axis_tdata[37:32]),
    .table_value_i  (s_axis_tdata[45:38]),
    .escape_code_i  (escape_q),
    .table_entries_i(entries_q),
    .q_count_i      (q_count),
    .push_o         (push)
  );

  // Result queue and output register
  rpsq_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .q_count_o     (q_count),
    .phred_offset_i(offset_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_o         (res)
  );

  assign m_axis_tdata = res.chr;
  assign m_axis_tuser = {res.err, res.last_pair, res.half, res.kind};
  assign m_axis_tlast = res.last_field;

endmodule

// ===== rtl/core/rpsq_ram.sv =====
module rpsq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/rpsq_front.sv =====
module rpsq_front
  import rpsq_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              opcode_i,
  input  logic [31:0]       token_value_i,
  input  logic [5:0]        table_index_i,
  input  logic [7:0]        table_value_i,
  input  logic [15:0]       escape_code_i,
  input  logic [6:0]        table_entries_i,
  input  logic [QCNT_W-1:0] q_count_i,
  output rpsq_push_t        push_o
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_SMARK  = 4'd1;
  localparam logic [3:0] PH_SLEN   = 4'd2;
  localparam logic [3:0] PH_BASES  = 4'd3;
  localparam logic [3:0] PH_QMARK  = 4'd4;
  localparam logic [3:0] PH_QLEN   = 4'd5;
  localparam logic [3:0] PH_QFIRST = 4'd6;
  localparam logic [3:0] PH_QDELTA = 4'd7;

  logic [3:0]             phase_q, phase_d;
  logic [LENGTH_BITS-1:0] rem_q, rem_d;
  logic [LENGTH_BITS-1:0] qlen_q, qlen_d;
  logic [IW-1:0]          prev_q, prev_d;
  logic                   esc_q, esc_d;
  logic                   half_q, half_d;

  logic                   s1_valid_q, s1_valid_d;
  rpsq_entry_t            s1_q, s1_d;
  logic [1:0]             s1_base_q, s1_base_d;

  logic                   accept;
  logic                   ram_we;
  logic [IW-1:0]          ram_waddr, ram_raddr;
  logic [7:0]             ram_rdata;

  logic [63:0]            tok_ext;
  logic [LENGTH_BITS-1:0] tok_len;
  logic [15:0]            ti_ext;
  logic [8:0]             bound9;
  logic [33:0]            bound34, tok34, half34, prev34, nxt;
  logic                   esc_ge, esc_eq, first_ok, delta_ok, rem_one;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (q_count_i + QCNT_W'(s1_valid_q)) < QCNT_W'(QUEUE_DEPTH);

  assign tok_ext = {32'b0, token_value_i};
  assign tok_len = tok_ext[LENGTH_BITS-1:0];
  assign ti_ext  = {10'b0, table_index_i};
  assign bound9  = ({2'b0, table_entries_i} > 9'(TABLE_DEPTH)) ? 9'(TABLE_DEPTH)
                                                               : {2'b0, table_entries_i};
  assign bound34 = {25'b0, bound9};
  assign tok34   = {2'b0, token_value_i};
  assign half34  = {3'b0, token_value_i[31:1]};
  assign prev34  = 34'(prev_q);
  assign nxt     = token_value_i[0] ? (prev34 - half34) : (prev34 + half34 - 34'd1);

  assign esc_ge   = token_value_i >= {16'b0, escape_code_i};
  assign esc_eq   = token_value_i == {16'b0, escape_code_i};
  assign first_ok = tok34 < bound34;
  assign delta_ok = !nxt[33] && (nxt < bound34);
  assign rem_one  = rem_q == LENGTH_BITS'(1);

  assign ram_we    = accept && (opcode_i == OP_LOAD) && (ti_ext < 16'(TABLE_DEPTH));
  assign ram_waddr = ti_ext[IW-1:0];

  always_comb begin
    phase_d    = phase_q;
    rem_d      = rem_q;
    qlen_d     = qlen_q;
    prev_d     = prev_q;
    esc_d      = esc_q;
    half_d     = half_q;
    s1_valid_d = 1'b0;
    s1_d       = '0;
    s1_base_d  = token_value_i[1:0];
    ram_raddr  = token_value_i[IW-1:0];
    s1_d.half  = half_q;

    if (accept && (opcode_i == OP_TOKEN)) begin
      case (phase_q)
        PH_IDLE: begin
          if (token_value_i == MARK_P) begin
            half_d  = 1'b0;
            phase_d = PH_SMARK;
          end else begin
            s1_valid_d = 1'b1;
            s1_d.err   = (token_value_i == MARK_G) ? ERR_GROUP : ERR_MARKER;
            half_d     = 1'b0;
            esc_d      = 1'b0;
          end
        end
        PH_SMARK, PH_QMARK: begin
          if (token_value_i == ((phase_q == PH_SMARK) ? MARK_S : MARK_Q)) begin
            phase_d = (phase_q == PH_SMARK) ? PH_SLEN : PH_QLEN;
            esc_d   = 1'b0;
          end else begin
            s1_valid_d = 1'b1;
            s1_d.err   = ERR_MARKER;
            phase_d    = PH_IDLE;
            half_d     = 1'b0;
            esc_d      = 1'b0;
          end
        end
        PH_SLEN: begin
          if (!esc_q && esc_ge) begin
            esc_d = 1'b1;
          end else begin
            esc_d   = 1'b0;
            rem_d   = tok_len;
            phase_d = (tok_len == '0) ? PH_QMARK : PH_BASES;
          end
        end
        PH_BASES: begin
          s1_valid_d      = 1'b1;
          s1_d.kind       = KIND_BASE;
          s1_d.last_field = rem_one;
          rem_d           = rem_q - LENGTH_BITS'(1);
          if (rem_one) begin
            phase_d = PH_QMARK;
          end
        end
        PH_QLEN: begin
          if (!esc_q && esc_ge) begin
            esc_d = 1'b1;
          end else begin
            esc_d   = 1'b0;
            qlen_d  = tok_len;
            phase_d = PH_QFIRST;
          end
        end
        PH_QFIRST, PH_QDELTA: begin
          if (!esc_q && esc_eq) begin
            esc_d = 1'b1;
          end else begin
            esc_d = 1'b0;
            if ((phase_q == PH_QFIRST) ? !first_ok : !delta_ok) begin
              s1_valid_d = 1'b1;
              s1_d.err   = ERR_INDEX;
              phase_d    = PH_IDLE;
              half_d     = 1'b0;
            end else begin
              // Emit a quality char, unless the first symbol of an empty string
              if (phase_q == PH_QDELTA) begin
                ram_raddr = nxt[IW-1:0];
              end
              prev_d = ram_raddr;
              if ((phase_q == PH_QFIRST) && (qlen_q == '0)) begin
                rem_d   = qlen_q;
                half_d  = !half_q;
                phase_d = half_q ? PH_IDLE : PH_SMARK;
              end else begin
                s1_valid_d      = 1'b1;
                s1_d.kind       = KIND_QUALITY;
                s1_d.last_field = (phase_q == PH_QFIRST) ? (qlen_q == LENGTH_BITS'(1))
                                                         : rem_one;
                s1_d.last_pair  = s1_d.last_field && half_q;
                rem_d           = ((phase_q == PH_QFIRST) ? qlen_q : rem_q)
                                  - LENGTH_BITS'(1);
                phase_d         = PH_QDELTA;
                if (s1_d.last_field) begin
                  half_d  = !half_q;
                  phase_d = half_q ? PH_IDLE : PH_SMARK;
                end
              end
            end
          end
        end
        default: begin
          s1_valid_d = 1'b1;
          s1_d.err   = ERR_MARKER;
          phase_d    = PH_IDLE;
          half_d     = 1'b0;
          esc_d      = 1'b0;
        end
      endcase
    end
  end

  rpsq_ram #(
    .WIDTH(8),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(table_value_i),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      rem_q      <= '0;
      qlen_q     <= '0;
      prev_q     <= '0;
      esc_q      <= 1'b0;
      half_q     <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      rem_q      <= rem_d;
      qlen_q     <= qlen_d;
      prev_q     <= prev_d;
      esc_q      <= esc_d;
      half_q     <= half_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q      <= s1_d;
    s1_base_q <= s1_base_d;
  end

  always_comb begin
    push_o.valid = s1_valid_q;
    push_o.entry = s1_q;
    if (s1_q.err != ERR_NONE) begin
      push_o.entry.chr = 8'h00;
    end else if (s1_q.kind == KIND_QUALITY) begin
      push_o.entry.chr = ram_rdata;
    end else begin
      push_o.entry.chr = base_letter(s1_base_q);
    end
  end

endmodule

// ===== rtl/core/rpsq_back.sv =====
module rpsq_back
  import rpsq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rpsq_push_t        push_i,
  output logic [QCNT_W-1:0] q_count_o,
  input  logic [7:0]        phred_offset_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rpsq_entry_t       out_o
);

  rpsq_entry_t       fifo_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              ov_q;
  rpsq_entry_t       out_q, out_d;
  logic              pop;
  rpsq_entry_t       head;

  assign pop  = (cnt_q != '0) && (!ov_q || out_ready_i);
  assign head = fifo_q[rptr_q];

  // Add the offset to quality chars
  always_comb begin
    out_d = head;
    if (head.kind == KIND_QUALITY) begin
      out_d.chr = head.chr + phred_offset_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      fifo_q[wptr_q] <= push_i.entry;
    end
    if (pop) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      if (push_i.valid) begin
        wptr_q <= wptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + QPTR_W'(1);
      end
      cnt_q <= cnt_q + QCNT_W'(push_i.valid) - QCNT_W'(pop);
      if (pop) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign q_count_o   = cnt_q;
  assign out_valid_o = ov_q;
  assign out_o       = out_q;

endmodule
